// ----- sv/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int BBA_LEVELS_DEF = 10;
    localparam int BLK_W          = 10;
    localparam int OP_W           = 2;
    localparam int ORD_W          = 4;
    localparam int ST_W           = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REBUILD = 2'd2,
        OP_RSVD    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_POP,
        S_SPLIT,
        S_SPLIT2,
        S_FREE,
        S_WALK,
        S_WALK_RD,
        S_UNLINK,
        S_UNLINK2,
        S_REBUILD,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [ORD_W-1:0]   order;
        logic [BLK_W-1:0]   block_index;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [BLK_W-1:0]   result_block;
    } t_rsp;

endpackage

`default_nettype wire

// ----- sv/buddy_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over a pool of block_count blocks with free lists per order.
//
//   channel  direction  handshake            payload
//   request  in         i_valid / o_ready    i_operation i_order i_block_index
//   result   out        o_valid / i_ready    o_status o_result_block
//   config   in         i_cfg_we             i_cfg_data (block_count)
//
// One transaction at a time; o_ready is high only while the sequencer is idle.
// Allocate pops a free list or splits a larger block level by level. Free walks
// the list of each order for the buddy and merges on a hit. Rebuild sets each head.
// A result waiting in the output register does not block the next request;
// reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_core #(
    parameter int LEVELS = bba_pkg::BBA_LEVELS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [bba_pkg::OP_W-1:0]  i_operation,
    input  wire logic [bba_pkg::ORD_W-1:0] i_order,
    input  wire logic [bba_pkg::BLK_W-1:0] i_block_index,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [bba_pkg::ST_W-1:0]       o_status,
    output logic [bba_pkg::BLK_W-1:0]      o_result_block,
    input  wire logic                      i_cfg_we,
    input  wire logic [bba_pkg::BLK_W-1:0] i_cfg_data
);
    import bba_pkg::*;

    logic [BLK_W-1:0] r_block_count;
    logic             r_ovalid, n_ovalid;
    t_rsp             r_out;
    t_req             req;
    t_rsp             rsp;
    logic             idle, done, load;

    assign req.op          = t_op'(i_operation);
    assign req.order       = i_order;
    assign req.block_index = i_block_index;

    bba_engine #(.LEVELS(LEVELS)) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_valid && idle),
        .i_req         (req),
        .i_block_count (r_block_count),
        .i_taken       (load),
        .o_idle        (idle),
        .o_done        (done),
        .o_rsp         (rsp)
    );

    assign load     = done && (!r_ovalid || i_ready);
    assign n_ovalid = load ? 1'b1 : (i_ready ? 1'b0 : r_ovalid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid      <= 1'b0;
            r_block_count <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_block_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= rsp;
        end
    end

    assign o_ready        = idle;
    assign o_valid        = r_ovalid;
    assign o_status       = r_out.status;
    assign o_result_block = r_out.result_block;

endmodule

`default_nettype wire

// ----- sv/bba_link_mem.sv -----
// ----------------------------------------------------------------------------
// bba_link_mem
// Link store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_link_mem #(
    parameter int AW = 10,
    parameter int DW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/bba_engine.sv -----
// ----------------------------------------------------------------------------
// bba_engine
// Sequencer for allocate, free and rebuild; owns the list heads and link store.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_engine #(
    parameter int LEVELS = bba_pkg::BBA_LEVELS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire bba_pkg::t_req             i_req,
    input  wire logic [bba_pkg::BLK_W-1:0] i_block_count,
    input  wire logic                      i_taken,
    output logic                           o_idle,
    output logic                           o_done,
    output bba_pkg::t_rsp                  o_rsp
);
    import bba_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW = LEVELS;
    localparam int HW = LEVELS + 1;
    localparam int CW = ((LEVELS > BLK_W) ? LEVELS : BLK_W) + 2;
    localparam logic [HW-1:0] NIL    = {1'b1, {LEVELS{1'b0}}};
    localparam logic [CW-1:0] POOL_C = CW'(1) << LEVELS;

    t_state r_state, n_state;

    logic [HW-1:0]    r_heads [LEVELS];
    logic [ORD_W-1:0] r_k, n_k;
    logic [ORD_W-1:0] r_i, n_i;
    logic [ORD_W-1:0] r_j, n_j;
    logic [ORD_W-1:0] r_lv, n_lv;
    logic [CW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_nb, n_nb;
    logic             r_has, n_has;
    logic [HW-1:0]    r_cur, n_cur;
    logic [HW-1:0]    r_prev, n_prev;
    logic [HW-1:0]    r_steps, n_steps;
    logic [HW-1:0]    r_s1, n_s1;
    logic [HW-1:0]    r_s2, n_s2;
    logic [AW-1:0]    r_off, n_off;
    t_status          r_status, n_status;
    logic [BLK_W-1:0] r_blk, n_blk;

    logic             hw_en;
    logic [LW-1:0]    hw_idx;
    logic [HW-1:0]    hw_val;
    logic             mw_en;
    logic [AW-1:0]    mw_addr;
    logic [HW-1:0]    mw_data;
    logic [AW-1:0]    mr_addr;
    logic [HW-1:0]    mr_data;

    logic [CW-1:0]    bc;
    logic [HW-1:0]    head_k, head_i, s1_c;
    logic [CW-1:0]    s2_c;
    logic             found_j;
    logic [ORD_W-1:0] j_c;
    logic [CW-1:0]    size_c, sh_c, nb_c;
    logic             has_c, free_bad, cur_nil, cur_hit;

    function automatic logic in_pool(input logic [CW-1:0] x, input logic [CW-1:0] cnt);
        in_pool = (x < cnt) && (x < POOL_C);
    endfunction

    bba_link_mem #(.AW(AW), .DW(HW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mw_en),
        .i_waddr (mw_addr),
        .i_wdata (mw_data),
        .i_raddr (mr_addr),
        .o_rdata (mr_data)
    );

    assign bc     = CW'(i_block_count);
    assign head_k = r_heads[r_k[LW-1:0]];
    assign head_i = r_heads[r_i[LW-1:0]];

    always_comb begin
        found_j = 1'b0;
        j_c     = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (l > int'(r_k) && r_heads[l] != NIL) begin
                found_j = 1'b1;
                j_c     = ORD_W'(l);
            end
        end
    end

    assign s1_c   = r_heads[j_c[LW-1:0]];
    assign s2_c   = CW'(s1_c) + (CW'(1) << (j_c - ORD_W'(1)));
    assign size_c = CW'(1) << r_i;
    assign sh_c   = r_n >> r_i;
    assign has_c  = sh_c[0] ? ((r_n + size_c) <= bc) : ((r_n + (size_c << 1)) <= bc);
    assign nb_c   = sh_c[0] ? (r_n - size_c) : (r_n + size_c);
    assign free_bad = (int'(r_i) >= LEVELS) || !in_pool(r_n, bc)
                    || ((r_n & (size_c - CW'(1))) != '0);
    assign cur_nil = (r_cur == NIL);
    assign cur_hit = r_has && (CW'(r_cur) == r_nb);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_req.op)
                        OP_ALLOC:   n_state = (int'(i_req.order) >= LEVELS) ? S_DONE : S_ALLOC;
                        OP_FREE:    n_state = S_FREE;
                        OP_REBUILD: n_state = (CW'(i_block_count) >= POOL_C) ? S_DONE
                                                                           : S_REBUILD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_ALLOC: begin
                if (head_k != NIL) begin
                    n_state = in_pool(CW'(head_k), bc) ? S_ALLOC_POP : S_DONE;
                end else if (!found_j) begin
                    n_state = S_DONE;
                end else begin
                    n_state = (in_pool(CW'(s1_c), bc) && in_pool(s2_c, bc)) ? S_SPLIT : S_DONE;
                end
            end
            S_ALLOC_POP: n_state = S_DONE;
            S_SPLIT:     n_state = S_SPLIT2;
            S_SPLIT2:    n_state = S_ALLOC;
            S_FREE:      n_state = free_bad ? S_DONE : S_WALK;
            S_WALK: begin
                if (cur_nil) begin
                    n_state = S_DONE;
                end else if (cur_hit) begin
                    n_state = in_pool(CW'(r_cur), bc) ? S_UNLINK : S_DONE;
                end else if (r_steps >= NIL || !in_pool(CW'(r_cur), bc)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: n_state = S_WALK;
            S_UNLINK: begin
                if (r_prev != NIL && !in_pool(CW'(r_prev), bc)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_UNLINK2;
                end
            end
            S_UNLINK2: n_state = (int'(r_i) + 1 >= LEVELS) ? S_DONE : S_FREE;
            S_REBUILD: n_state = (r_lv == '0) ? S_DONE : S_REBUILD;
            S_DONE:    n_state = i_taken ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_k      = r_k;
        n_i      = r_i;
        n_j      = r_j;
        n_lv     = r_lv;
        n_n      = r_n;
        n_nb     = r_nb;
        n_has    = r_has;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_steps  = r_steps;
        n_s1     = r_s1;
        n_s2     = r_s2;
        n_off    = r_off;
        n_status = r_status;
        n_blk    = r_blk;
        hw_en    = 1'b0;
        hw_idx   = '0;
        hw_val   = NIL;
        mw_en    = 1'b0;
        mw_addr  = '0;
        mw_data  = NIL;
        mr_addr  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_k      = i_req.order;
                    n_i      = i_req.order;
                    n_n      = CW'(i_req.block_index);
                    n_lv     = ORD_W'(LEVELS - 1);
                    n_off    = '0;
                    n_blk    = '0;
                    n_status = ST_OK;
                    if (i_req.op == OP_RSVD) begin
                        n_status = ST_BAD;
                    end else if (i_req.op == OP_ALLOC && int'(i_req.order) >= LEVELS) begin
                        n_status = ST_BAD;
                    end else if (i_req.op == OP_REBUILD && CW'(i_block_count) >= POOL_C) begin
                        n_status = ST_BAD;
                    end
                end
            end
            S_ALLOC: begin
                if (head_k != NIL) begin
                    n_cur   = head_k;
                    mr_addr = head_k[AW-1:0];
                    if (!in_pool(CW'(head_k), bc)) begin
                        n_status = ST_BAD;
                    end
                end else if (!found_j) begin
                    n_status = ST_NOMEM;
                end else begin
                    n_j     = j_c;
                    n_s1    = s1_c;
                    n_s2    = HW'(s2_c);
                    mr_addr = s1_c[AW-1:0];
                    if (!(in_pool(CW'(s1_c), bc) && in_pool(s2_c, bc))) begin
                        n_status = ST_BAD;
                    end
                end
            end
            S_ALLOC_POP: begin
                hw_en  = 1'b1;
                hw_idx = r_k[LW-1:0];
                hw_val = mr_data;
                n_blk  = BLK_W'(r_cur);
            end
            S_SPLIT: begin
                hw_en   = 1'b1;
                hw_idx  = r_j[LW-1:0];
                hw_val  = mr_data;
                mw_en   = 1'b1;
                mw_addr = r_s2[AW-1:0];
                mw_data = r_heads[LW'(r_j - ORD_W'(1))];
            end
            S_SPLIT2: begin
                mw_en   = 1'b1;
                mw_addr = r_s1[AW-1:0];
                mw_data = r_s2;
                hw_en   = 1'b1;
                hw_idx  = LW'(r_j - ORD_W'(1));
                hw_val  = r_s1;
            end
            S_FREE: begin
                if (free_bad) begin
                    n_status = ST_BAD;
                end else begin
                    n_has   = has_c;
                    n_nb    = nb_c;
                    n_cur   = head_i;
                    n_prev  = NIL;
                    n_steps = '0;
                end
            end
            S_WALK: begin
                if (cur_nil) begin
                    mw_en   = 1'b1;
                    mw_addr = r_n[AW-1:0];
                    mw_data = head_i;
                    hw_en   = 1'b1;
                    hw_idx  = r_i[LW-1:0];
                    hw_val  = HW'(r_n);
                end else if (cur_hit) begin
                    mr_addr = r_cur[AW-1:0];
                    if (!in_pool(CW'(r_cur), bc)) begin
                        n_status = ST_BAD;
                    end
                end else if (r_steps >= NIL || !in_pool(CW'(r_cur), bc)) begin
                    n_status = ST_BAD;
                end else begin
                    n_prev  = r_cur;
                    mr_addr = r_cur[AW-1:0];
                    n_steps = r_steps + HW'(1);
                end
            end
            S_WALK_RD: begin
                n_cur = mr_data;
            end
            S_UNLINK: begin
                if (r_prev != NIL) begin
                    if (in_pool(CW'(r_prev), bc)) begin
                        mw_en   = 1'b1;
                        mw_addr = r_prev[AW-1:0];
                        mw_data = mr_data;
                    end else begin
                        n_status = ST_BAD;
                    end
                end else begin
                    hw_en  = 1'b1;
                    hw_idx = r_i[LW-1:0];
                    hw_val = mr_data;
                end
            end
            S_UNLINK2: begin
                mw_en   = 1'b1;
                mw_addr = r_cur[AW-1:0];
                mw_data = NIL;
                if (int'(r_i) + 1 >= LEVELS) begin
                    n_status = ST_BAD;
                end else begin
                    n_n = (r_n < r_nb) ? r_n : r_nb;
                    n_i = r_i + ORD_W'(1);
                end
            end
            S_REBUILD: begin
                hw_en  = 1'b1;
                hw_idx = r_lv[LW-1:0];
                if (bc[r_lv]) begin
                    hw_val  = HW'(r_off);
                    mw_en   = 1'b1;
                    mw_addr = r_off;
                    mw_data = NIL;
                    n_off   = r_off + (AW'(1) << r_lv);
                end
                n_lv = r_lv - ORD_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int l = 0; l < LEVELS; l++) begin
                r_heads[l] <= NIL;
            end
        end else begin
            r_state <= n_state;
            if (hw_en) begin
                r_heads[hw_idx] <= hw_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_i      <= n_i;
        r_j      <= n_j;
        r_lv     <= n_lv;
        r_n      <= n_n;
        r_nb     <= n_nb;
        r_has    <= n_has;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_off    <= n_off;
        r_status <= n_status;
        r_blk    <= n_blk;
    end

    assign o_idle             = (r_state == S_IDLE);
    assign o_done             = (r_state == S_DONE);
    assign o_rsp.status       = r_status;
    assign o_rsp.result_block = (r_status == ST_OK) ? r_blk : '0;

endmodule

`default_nettype wire

// ----- sv/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      o_ready,
    input  wire logic                      o_valid,
    input  wire logic                      i_ready,
    input  wire logic [bba_pkg::ST_W-1:0]  o_status,
    input  wire logic [bba_pkg::BLK_W-1:0] o_result_block
);
    import bba_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_result_block))
        else $error("stalled result changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_NOMEM || o_status == ST_BAD))
        else $error("undefined status code");

    a_blk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_result_block == '0)
        else $error("block index on failed transaction");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accepting a transaction");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);

`default_nettype wire
